// ----- rtl/sph_pkg.sv -----
// ----------------------------------------------------------------------------
// sph_pkg
// Widths, stage counts and pipeline record types for the softened
// point-source field and tidal tensor pipeline.
// ----------------------------------------------------------------------------
package sph_pkg;

  localparam int CW       = 32;
  localparam int RESW     = 48;
  localparam int FRAC_IN  = 16;
  localparam int FRAC_OUT = 24;

  localparam int DW   = CW + 1;
  localparam int SW   = 2 * DW + 1;
  localparam int RW   = DW;
  localparam int DENW = 5 * RW;
  localparam int QW   = RESW;
  localparam int DVW  = DENW + QW;
  localparam int MAW  = CW + DW;
  localparam int HNW  = SW + CW;
  localparam int HLO  = SW - RW;

  localparam int FSH = FRAC_IN + FRAC_OUT;
  localparam int HSH = 2 * FRAC_IN + FRAC_OUT;

  localparam int NSTAGE = 11 + RW + QW;

  localparam logic [CW-1:0] EPS_RESET = CW'(65536);

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [RW-1:0] root;
    logic [SW-1:0] s;
    logic [SW-1:0] t3a;
    logic [SW-1:0] t3b;
    logic [SW-1:0] ab3;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [CW-1:0] m;
    logic          ndx;
    logic          ndy;
  } sq_t;

  typedef struct packed {
    logic [DVW-1:0]  rem;
    logic [DENW-1:0] den;
    logic [QW-1:0]   q;
    logic            neg;
    logic            sat;
  } div_t;

endpackage

// ----- rtl/sph_div.sv -----
// ----------------------------------------------------------------------------
// sph_div
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the truncated quotient to the result width.
// ----------------------------------------------------------------------------
module sph_div (
  input  logic                     clk,
  input  logic [sph_pkg::DVW-1:0]  num,
  input  logic [sph_pkg::DENW-1:0] den,
  input  logic                     neg,
  output logic [sph_pkg::RESW-1:0] quot
);
  import sph_pkg::*;

  div_t st [0:QW];
  div_t st_next [0:QW-1];
  logic [QW-1:0] mag;

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      st_next[j] = st[j];
      if (st[j].rem >= (DVW'(st[j].den) << (QW - 1 - j))) begin
        st_next[j].rem = st[j].rem - (DVW'(st[j].den) << (QW - 1 - j));
        st_next[j].q[QW-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st[0].rem <= num;
    st[0].den <= den;
    st[0].q   <= '0;
    st[0].neg <= neg;
    st[0].sat <= (num >= (DVW'(den) << QW));
    for (int j = 0; j < QW; j++) begin
      st[j+1] <= st_next[j];
    end
  end

  always_comb begin
    mag = st[QW].q;
    if (st[QW].neg) begin
      if (st[QW].sat || (st[QW].q[QW-1] && (|st[QW].q[QW-2:0]))) begin
        mag = QW'(1) << (QW - 1);
      end
    end else begin
      if (st[QW].sat || st[QW].q[QW-1]) begin
        mag = (QW'(1) << (QW - 1)) - QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    quot <= st[QW].neg ? RESW'(-mag) : RESW'(mag);
  end

endmodule

// ----- rtl/softened_point_source_hessian.sv -----
// ----------------------------------------------------------------------------
// softened_point_source_hessian
// Planar field and tidal tensor of a Plummer-softened point mass.
// Throughput: one request per cycle; busy is always low.
// Depth is set by the 33-stage square root and the 48-stage dividers.
// Synchronous reset clears the valid line and sets softening to 1.0.
// ----------------------------------------------------------------------------
module softened_point_source_hessian (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  output logic                            done,
  input  logic                            cfg_we,
  input  logic        [sph_pkg::CW-1:0]   cfg_data,
  input  logic signed [sph_pkg::CW-1:0]   source_x,
  input  logic signed [sph_pkg::CW-1:0]   source_y,
  input  logic        [sph_pkg::CW-1:0]   source_mass,
  input  logic signed [sph_pkg::CW-1:0]   point_x,
  input  logic signed [sph_pkg::CW-1:0]   point_y,
  output logic signed [sph_pkg::RESW-1:0] field_x,
  output logic signed [sph_pkg::RESW-1:0] field_y,
  output logic signed [sph_pkg::RESW-1:0] hess_xx,
  output logic signed [sph_pkg::RESW-1:0] hess_xy,
  output logic signed [sph_pkg::RESW-1:0] hess_yy,
  output logic signed [sph_pkg::RESW-1:0] hess_zz
);
  import sph_pkg::*;

  logic [CW-1:0]     eps;
  logic [NSTAGE-1:0] vld;
  logic              accept;

  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0]        st0_a, st0_b;
  logic                 st0_ndx, st0_ndy;
  logic [CW-1:0]        st0_m, st0_e;

  logic [2*DW-1:0] st1_a2, st1_b2, st1_e2, st1_ab;
  logic [DW-1:0]   st1_a, st1_b;
  logic [CW-1:0]   st1_m;
  logic            st1_ndx, st1_ndy;

  sq_t sq [0:RW];
  sq_t sq_next [0:RW-1];

  logic [RW-1:0]   rr;
  logic [RW-1:0]   p1_r;
  logic [2*RW-1:0] p1_r2;
  logic [SW-1:0]   p1_dxx, p1_dyy, p1_ab3, p1_s;
  logic            p1_xneg, p1_yneg, p1_ndx, p1_ndy;
  logic [MAW-1:0]  p1_na, p1_nb;
  logic [CW-1:0]   p1_m;

  logic [2*RW-1:0]   p2_r2, p2_r3l, p2_r3h;
  logic [HLO+CW-1:0] p2_xxl, p2_yyl, p2_xyl, p2_zzl;
  logic [RW+CW-1:0]  p2_xxh, p2_yyh, p2_xyh, p2_zzh;
  logic [MAW-1:0]    p2_na, p2_nb;
  logic              p2_xneg, p2_yneg, p2_ndx, p2_ndy;

  logic [2*RW-1:0] p3_r2;
  logic [3*RW-1:0] p3_r3;
  logic [HNW-1:0]  p3_nxx, p3_nyy, p3_nxy, p3_nzz;
  logic [MAW-1:0]  p3_na, p3_nb;
  logic            p3_xneg, p3_yneg, p3_ndx, p3_ndy;

  logic [2*RW-1:0] p4_m00, p4_m01, p4_m10, p4_m11, p4_m20, p4_m21;
  logic [3*RW-1:0] p4_r3;
  logic [HNW-1:0]  p4_nxx, p4_nyy, p4_nxy, p4_nzz;
  logic [MAW-1:0]  p4_na, p4_nb;
  logic            p4_xneg, p4_yneg, p4_ndx, p4_ndy;

  logic [DENW-1:0] p5_lo, p5_hi;
  logic [3*RW-1:0] p5_r3;
  logic [HNW-1:0]  p5_nxx, p5_nyy, p5_nxy, p5_nzz;
  logic [MAW-1:0]  p5_na, p5_nb;
  logic            p5_xneg, p5_yneg, p5_ndx, p5_ndy;

  logic [DENW-1:0] p6_r5;
  logic [3*RW-1:0] p6_r3;
  logic [HNW-1:0]  p6_nxx, p6_nyy, p6_nxy, p6_nzz;
  logic [MAW-1:0]  p6_na, p6_nb;
  logic            p6_xneg, p6_yneg, p6_ndx, p6_ndy;

  logic [RESW-1:0] q_fx, q_fy, q_xx, q_xy, q_yy, q_zz;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
      vld <= '0;
    end else begin
      if (cfg_we) begin
        eps <= cfg_data;
      end
      vld <= {vld[NSTAGE-2:0], accept};
    end
  end

  assign dx = DW'(point_x) - DW'(source_x);
  assign dy = DW'(point_y) - DW'(source_y);

  always_ff @(posedge clk) begin
    st0_ndx <= dx[DW-1];
    st0_ndy <= dy[DW-1];
    st0_a   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
    st0_b   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
    st0_m   <= source_mass;
    st0_e   <= eps;

    st1_a2  <= (2*DW)'(st0_a) * (2*DW)'(st0_a);
    st1_b2  <= (2*DW)'(st0_b) * (2*DW)'(st0_b);
    st1_e2  <= (2*DW)'(st0_e) * (2*DW)'(st0_e);
    st1_ab  <= (2*DW)'(st0_a) * (2*DW)'(st0_b);
    st1_a   <= st0_a;
    st1_b   <= st0_b;
    st1_m   <= st0_m;
    st1_ndx <= st0_ndx;
    st1_ndy <= st0_ndy;
  end

  // square root, one root bit per stage
  always_comb begin
    for (int j = 0; j < RW; j++) begin
      sq_next[j] = sq[j];
      if (sq[j].rem >= ((SW'(sq[j].root) << (RW - j)) | (SW'(1) << (2 * (RW - 1 - j)))))
      begin
        sq_next[j].rem = sq[j].rem -
          ((SW'(sq[j].root) << (RW - j)) | (SW'(1) << (2 * (RW - 1 - j))));
        sq_next[j].root[RW-1-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq[0].s    <= SW'(st1_a2) + SW'(st1_b2) + SW'(st1_e2);
    sq[0].rem  <= SW'(st1_a2) + SW'(st1_b2) + SW'(st1_e2);
    sq[0].root <= '0;
    sq[0].t3a  <= SW'(st1_a2) + (SW'(st1_a2) << 1);
    sq[0].t3b  <= SW'(st1_b2) + (SW'(st1_b2) << 1);
    sq[0].ab3  <= SW'(st1_ab) + (SW'(st1_ab) << 1);
    sq[0].a    <= st1_a;
    sq[0].b    <= st1_b;
    sq[0].m    <= st1_m;
    sq[0].ndx  <= st1_ndx;
    sq[0].ndy  <= st1_ndy;
    for (int j = 0; j < RW; j++) begin
      sq[j+1] <= sq_next[j];
    end
  end

  assign rr = (sq[RW].root == '0) ? RW'(1) : sq[RW].root;

  // wide products are split into partial products of 33- and 34-bit slices over several stages
  always_ff @(posedge clk) begin
    p1_r    <= rr;
    p1_r2   <= (2*RW)'(rr) * (2*RW)'(rr);
    p1_xneg <= sq[RW].s < sq[RW].t3a;
    p1_yneg <= sq[RW].s < sq[RW].t3b;
    p1_dxx  <= (sq[RW].s < sq[RW].t3a) ? sq[RW].t3a - sq[RW].s : sq[RW].s - sq[RW].t3a;
    p1_dyy  <= (sq[RW].s < sq[RW].t3b) ? sq[RW].t3b - sq[RW].s : sq[RW].s - sq[RW].t3b;
    p1_na   <= MAW'(sq[RW].m) * MAW'(sq[RW].a);
    p1_nb   <= MAW'(sq[RW].m) * MAW'(sq[RW].b);
    p1_ab3  <= sq[RW].ab3;
    p1_s    <= sq[RW].s;
    p1_m    <= sq[RW].m;
    p1_ndx  <= sq[RW].ndx;
    p1_ndy  <= sq[RW].ndy;

    p2_r2   <= p1_r2;
    p2_r3l  <= (2*RW)'(p1_r2[RW-1:0]) * (2*RW)'(p1_r);
    p2_r3h  <= (2*RW)'(p1_r2[2*RW-1:RW]) * (2*RW)'(p1_r);
    p2_xxl  <= (HLO+CW)'(p1_dxx[HLO-1:0]) * (HLO+CW)'(p1_m);
    p2_xxh  <= (RW+CW)'(p1_dxx[SW-1:HLO]) * (RW+CW)'(p1_m);
    p2_yyl  <= (HLO+CW)'(p1_dyy[HLO-1:0]) * (HLO+CW)'(p1_m);
    p2_yyh  <= (RW+CW)'(p1_dyy[SW-1:HLO]) * (RW+CW)'(p1_m);
    p2_xyl  <= (HLO+CW)'(p1_ab3[HLO-1:0]) * (HLO+CW)'(p1_m);
    p2_xyh  <= (RW+CW)'(p1_ab3[SW-1:HLO]) * (RW+CW)'(p1_m);
    p2_zzl  <= (HLO+CW)'(p1_s[HLO-1:0]) * (HLO+CW)'(p1_m);
    p2_zzh  <= (RW+CW)'(p1_s[SW-1:HLO]) * (RW+CW)'(p1_m);
    p2_na   <= p1_na;
    p2_nb   <= p1_nb;
    p2_xneg <= p1_xneg;
    p2_yneg <= p1_yneg;
    p2_ndx  <= p1_ndx;
    p2_ndy  <= p1_ndy;

    p3_r2   <= p2_r2;
    p3_r3   <= ((3*RW)'(p2_r3h) << RW) + (3*RW)'(p2_r3l);
    p3_nxx  <= (HNW'(p2_xxh) << HLO) + HNW'(p2_xxl);
    p3_nyy  <= (HNW'(p2_yyh) << HLO) + HNW'(p2_yyl);
    p3_nxy  <= (HNW'(p2_xyh) << HLO) + HNW'(p2_xyl);
    p3_nzz  <= (HNW'(p2_zzh) << HLO) + HNW'(p2_zzl);
    p3_na   <= p2_na;
    p3_nb   <= p2_nb;
    p3_xneg <= p2_xneg;
    p3_yneg <= p2_yneg;
    p3_ndx  <= p2_ndx;
    p3_ndy  <= p2_ndy;

    p4_m00  <= (2*RW)'(p3_r3[RW-1:0]) * (2*RW)'(p3_r2[RW-1:0]);
    p4_m01  <= (2*RW)'(p3_r3[RW-1:0]) * (2*RW)'(p3_r2[2*RW-1:RW]);
    p4_m10  <= (2*RW)'(p3_r3[2*RW-1:RW]) * (2*RW)'(p3_r2[RW-1:0]);
    p4_m11  <= (2*RW)'(p3_r3[2*RW-1:RW]) * (2*RW)'(p3_r2[2*RW-1:RW]);
    p4_m20  <= (2*RW)'(p3_r3[3*RW-1:2*RW]) * (2*RW)'(p3_r2[RW-1:0]);
    p4_m21  <= (2*RW)'(p3_r3[3*RW-1:2*RW]) * (2*RW)'(p3_r2[2*RW-1:RW]);
    p4_r3   <= p3_r3;
    p4_nxx  <= p3_nxx;
    p4_nyy  <= p3_nyy;
    p4_nxy  <= p3_nxy;
    p4_nzz  <= p3_nzz;
    p4_na   <= p3_na;
    p4_nb   <= p3_nb;
    p4_xneg <= p3_xneg;
    p4_yneg <= p3_yneg;
    p4_ndx  <= p3_ndx;
    p4_ndy  <= p3_ndy;

    p5_lo   <= DENW'(p4_m00) + (DENW'(p4_m01) << RW) + (DENW'(p4_m10) << RW);
    p5_hi   <= DENW'(p4_m11) + DENW'(p4_m20) + (DENW'(p4_m21) << RW);
    p5_r3   <= p4_r3;
    p5_nxx  <= p4_nxx;
    p5_nyy  <= p4_nyy;
    p5_nxy  <= p4_nxy;
    p5_nzz  <= p4_nzz;
    p5_na   <= p4_na;
    p5_nb   <= p4_nb;
    p5_xneg <= p4_xneg;
    p5_yneg <= p4_yneg;
    p5_ndx  <= p4_ndx;
    p5_ndy  <= p4_ndy;

    p6_r5   <= p5_lo + (p5_hi << (2 * RW));
    p6_r3   <= p5_r3;
    p6_nxx  <= p5_nxx;
    p6_nyy  <= p5_nyy;
    p6_nxy  <= p5_nxy;
    p6_nzz  <= p5_nzz;
    p6_na   <= p5_na;
    p6_nb   <= p5_nb;
    p6_xneg <= p5_xneg;
    p6_yneg <= p5_yneg;
    p6_ndx  <= p5_ndx;
    p6_ndy  <= p5_ndy;
  end

  sph_div u_div_fx (.clk(clk), .num(DVW'(p6_na) << FSH), .den(DENW'(p6_r3)),
                    .neg(p6_ndx), .quot(q_fx));
  sph_div u_div_fy (.clk(clk), .num(DVW'(p6_nb) << FSH), .den(DENW'(p6_r3)),
                    .neg(p6_ndy), .quot(q_fy));
  sph_div u_div_xx (.clk(clk), .num(DVW'(p6_nxx) << HSH), .den(p6_r5),
                    .neg(p6_xneg), .quot(q_xx));
  sph_div u_div_xy (.clk(clk), .num(DVW'(p6_nxy) << HSH), .den(p6_r5),
                    .neg(p6_ndx == p6_ndy), .quot(q_xy));
  sph_div u_div_yy (.clk(clk), .num(DVW'(p6_nyy) << HSH), .den(p6_r5),
                    .neg(p6_yneg), .quot(q_yy));
  sph_div u_div_zz (.clk(clk), .num(DVW'(p6_nzz) << HSH), .den(p6_r5),
                    .neg(1'b0), .quot(q_zz));

  assign field_x = $signed(q_fx);
  assign field_y = $signed(q_fy);
  assign hess_xx = $signed(q_xx);
  assign hess_xy = $signed(q_xy);
  assign hess_yy = $signed(q_yy);
  assign hess_zz = $signed(q_zz);

endmodule

// ----- rtl/sph_check.sv -----
// ----------------------------------------------------------------------------
// sph_check
// Port-level checks of request timing and result sign for the pipeline.
// ----------------------------------------------------------------------------
module sph_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic signed [sph_pkg::RESW-1:0] hess_zz
);
  import sph_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##NSTAGE done)
    else $error("request result missing");

  a_done_caused: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, NSTAGE))
    else $error("result without request");

  a_zz_sign: assert property (@(posedge clk) disable iff (rst)
    done |-> !hess_zz[RESW-1])
    else $error("negative zz entry");

endmodule

bind softened_point_source_hessian sph_check u_sph_check (.*);
